>>> src/ntcfan_pkg.sv
// Package with types, constants and the resistance table of the NTC fan selector.
`default_nettype none
package ntcfan_pkg;

  localparam int unsigned NumChannels    = 3;
  localparam int unsigned AdcFullScale   = 4095;
  localparam int unsigned PullupOhms     = 10000;
  localparam int unsigned TablePoints    = 166;
  localparam int          TableT0Tenths  = -400;
  localparam int          TableTopTenths = 1250;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [CfgIdxW-1:0] CfgThrHigh   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgThrLow    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHyst      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpeedHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSpeedNorm = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPwmReload = 3'd5;

  localparam logic [1:0] StNormal   = 2'd0;
  localparam logic [1:0] StWarm     = 2'd1;
  localparam logic [1:0] StOverheat = 2'd2;

  typedef struct packed {
    logic [11:0] adc_ch2;
    logic [11:0] adc_ch1;
    logic [11:0] adc_ch0;
  } ntc_in_t;

  typedef struct packed {
    logic signed [11:0] temp_ch0;
    logic signed [11:0] temp_ch1;
    logic signed [11:0] temp_ch2;
    logic [1:0]         status_ch0;
    logic [1:0]         status_ch1;
    logic [1:0]         status_ch2;
    logic [6:0]         fan_duty;
    logic [16:0]        pwm_compare;
  } ntc_out_t;

  function automatic logic [17:0] ntc_ohms(input logic [7:0] idx);
    logic [17:0] r;
    unique case (idx)
      8'd0: r=18'd197390; 8'd1: r=18'd186540; 8'd2: r=18'd176350; 8'd3: r=18'd166800;
      8'd4: r=18'd157820; 8'd5: r=18'd149390; 8'd6: r=18'd141510; 8'd7: r=18'd134090;
      8'd8: r=18'd127110; 8'd9: r=18'd120530; 8'd10: r=18'd114340; 8'd11: r=18'd108530;
      8'd12: r=18'd103040; 8'd13: r=18'd97870; 8'd14: r=18'd92989; 8'd15: r=18'd88381;
      8'd16: r=18'd84036; 8'd17: r=18'd79931; 8'd18: r=18'd76052; 8'd19: r=18'd72384;
      8'd20: r=18'd68915; 8'd21: r=18'd65634; 8'd22: r=18'd62529; 8'd23: r=18'd59589;
      8'd24: r=18'd56804; 8'd25: r=18'd54166; 8'd26: r=18'd51665; 8'd27: r=18'd49294;
      8'd28: r=18'd47046; 8'd29: r=18'd44913; 8'd30: r=18'd42889; 8'd31: r=18'd40967;
      8'd32: r=18'd39142; 8'd33: r=18'd37408; 8'd34: r=18'd35761; 8'd35: r=18'd34196;
      8'd36: r=18'd32707; 8'd37: r=18'd31291; 8'd38: r=18'd29945; 8'd39: r=18'd28664;
      8'd40: r=18'd27445; 8'd41: r=18'd26283; 8'd42: r=18'd25177; 8'd43: r=18'd24124;
      8'd44: r=18'd23121; 8'd45: r=18'd22165; 8'd46: r=18'd21253; 8'd47: r=18'd20384;
      8'd48: r=18'd19555; 8'd49: r=18'd18764; 8'd50: r=18'd18010; 8'd51: r=18'd17290;
      8'd52: r=18'd16602; 8'd53: r=18'd15946; 8'd54: r=18'd15319; 8'd55: r=18'd14720;
      8'd56: r=18'd14148; 8'd57: r=18'd13601; 8'd58: r=18'd13078; 8'd59: r=18'd12578;
      8'd60: r=18'd12099; 8'd61: r=18'd11642; 8'd62: r=18'd11204; 8'd63: r=18'd10785;
      8'd64: r=18'd10384; 8'd65: r=18'd10000; 8'd66: r=18'd9632; 8'd67: r=18'd9280;
      8'd68: r=18'd8943; 8'd69: r=18'd8619; 8'd70: r=18'd8309; 8'd71: r=18'd8012;
      8'd72: r=18'd7727; 8'd73: r=18'd7453; 8'd74: r=18'd7191; 8'd75: r=18'd6939;
      8'd76: r=18'd6698; 8'd77: r=18'd6466; 8'd78: r=18'd6243; 8'd79: r=18'd6029;
      8'd80: r=18'd5824; 8'd81: r=18'd5627; 8'd82: r=18'd5437; 8'd83: r=18'd5255;
      8'd84: r=18'd5080; 8'd85: r=18'd4911; 8'd86: r=18'd4749; 8'd87: r=18'd4593;
      8'd88: r=18'd4443; 8'd89: r=18'd4299; 8'd90: r=18'd4160; 8'd91: r=18'd4027;
      8'd92: r=18'd3898; 8'd93: r=18'd3774; 8'd94: r=18'd3654; 8'd95: r=18'd3539;
      8'd96: r=18'd3429; 8'd97: r=18'd3322; 8'd98: r=18'd3219; 8'd99: r=18'd3119;
      8'd100: r=18'd3024; 8'd101: r=18'd2931; 8'd102: r=18'd2842; 8'd103: r=18'd2756;
      8'd104: r=18'd2673; 8'd105: r=18'd2593; 8'd106: r=18'd2516; 8'd107: r=18'd2441;
      8'd108: r=18'd2369; 8'd109: r=18'd2300; 8'd110: r=18'd2233; 8'd111: r=18'd2168;
      8'd112: r=18'd2105; 8'd113: r=18'd2044; 8'd114: r=18'd1986; 8'd115: r=18'd1929;
      8'd116: r=18'd1874; 8'd117: r=18'd1821; 8'd118: r=18'd1770; 8'd119: r=18'd1720;
      8'd120: r=18'd1673; 8'd121: r=18'd1626; 8'd122: r=18'd1581; 8'd123: r=18'd1538;
      8'd124: r=18'd1496; 8'd125: r=18'd1455; 8'd126: r=18'd1416; 8'd127: r=18'd1377;
      8'd128: r=18'd1340; 8'd129: r=18'd1304; 8'd130: r=18'd1270; 8'd131: r=18'd1236;
      8'd132: r=18'd1204; 8'd133: r=18'd1172; 8'd134: r=18'd1141; 8'd135: r=18'd1112;
      8'd136: r=18'd1083; 8'd137: r=18'd1055; 8'd138: r=18'd1028; 8'd139: r=18'd1002;
      8'd140: r=18'd976; 8'd141: r=18'd951; 8'd142: r=18'd927; 8'd143: r=18'd904;
      8'd144: r=18'd882; 8'd145: r=18'd860; 8'd146: r=18'd838; 8'd147: r=18'd818;
      8'd148: r=18'd798; 8'd149: r=18'd778; 8'd150: r=18'd759; 8'd151: r=18'd741;
      8'd152: r=18'd723; 8'd153: r=18'd706; 8'd154: r=18'd689; 8'd155: r=18'd673;
      8'd156: r=18'd657; 8'd157: r=18'd641; 8'd158: r=18'd626; 8'd159: r=18'd612;
      8'd160: r=18'd598; 8'd161: r=18'd584; 8'd162: r=18'd570; 8'd163: r=18'd557;
      8'd164: r=18'd545; 8'd165: r=18'd532;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/ntc_thermal_monitor_fan_select_top.sv
// Top level of the NTC thermal monitor with hysteresis status and fan duty selection.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_stall_o  ntc_in_t   (three ADC codes)
//   out      source     out_valid_o/out_stall_i ntc_out_t (temps, status, duty, compare)
//   cfg      sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
// One transaction is worked on at a time. Each channel takes a setup step, a division on the
// shared bit-serial divider for the resistance, a walk of one table point per cycle (up to 165),
// a second division for the interpolation fraction and a status step; rail codes skip the
// division and the walk. Last come the duty choice and the compare value. Reset sets status,
// duty and configuration to their defaults and clears the handshake control. The result
// register holds while out_stall_i is high; the next input is taken only once it has left.
`default_nettype none
module ntc_thermal_monitor_fan_select_top #(
  parameter int unsigned CHANNELS       = ntcfan_pkg::NumChannels,
  parameter int unsigned ADC_FULL_SCALE = ntcfan_pkg::AdcFullScale,
  parameter int unsigned PULLUP_OHMS    = ntcfan_pkg::PullupOhms
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire ntcfan_pkg::ntc_in_t           in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output ntcfan_pkg::ntc_out_t               out_data_o,
  input  wire                                cfg_we_i,
  input  wire [ntcfan_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [ntcfan_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ntcfan_pkg::*;

  // Dividend width: PULLUP_OHMS*adc, with adc up to 16 bits and the pull-up to 17.
  localparam int unsigned DW = 34;
  localparam int unsigned CW = $clog2(DW + 1);
  // ceil(2^30 / 100); exact for every duty*(reload+1) product, which stays below 2^23.
  localparam logic [23:0] PctRecip = 24'd10737419;

  typedef enum logic [3:0] {
    S_IDLE, S_CHAN, S_RDIV, S_SRCH, S_FDIV, S_NEXT, S_CDIV, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0] ch_q;
  logic [15:0] adc_q [3];
  logic [1:0]  st_q [3];
  logic signed [11:0] temp_q [3];
  logic [6:0] duty_q;
  logic [11:0] thr_hi_q, thr_lo_q;
  logic [8:0] hyst_q;
  logic [7:0] spd_hi_q, spd_no_q;
  logic [15:0] reload_q;
  logic [7:0] idx_q;
  logic [17:0] r_q;
  ntc_out_t out_q;
  logic out_valid_q;

  // Shared restoring divider: quotient shifts into num_q, remainder into rem_q.
  logic [DW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   rem_sh;
  logic          sub_ok;
  assign rem_sh = {rem_q[DW-1:0], num_q[DW-1]};
  assign sub_ok = rem_sh >= {1'b0, den_q};

  // The compare value divides by 100 with a reciprocal multiply; the quotient is bits 46:30.
  logic [46:0] cmp_prod;
  assign cmp_prod = num_q[22:0] * PctRecip;

  logic [17:0] tab_cur, tab_prev;
  assign tab_cur  = ntc_ohms(idx_q);
  assign tab_prev = ntc_ohms(idx_q - 8'd1);

  // Hysteresis update for the current channel.
  logic signed [12:0] t_x, hi_x, lo_x, hi_rel, lo_rel;
  logic [1:0] st_new;
  always_comb begin
    t_x    = 13'(temp_q[ch_q]);
    hi_x   = 13'(signed'(thr_hi_q));
    lo_x   = 13'(signed'(thr_lo_q));
    hi_rel = hi_x - signed'({4'd0, hyst_q});
    lo_rel = lo_x - signed'({4'd0, hyst_q});
    unique case (st_q[ch_q])
      StNormal:   st_new = (t_x >= hi_x) ? StOverheat : (t_x >= lo_x) ? StWarm : StNormal;
      StWarm:     st_new = (t_x >= hi_x) ? StOverheat : (t_x < lo_rel) ? StNormal : StWarm;
      StOverheat: st_new = (t_x < hi_rel) ? ((t_x >= lo_x) ? StWarm : StNormal) : StOverheat;
      default:    st_new = StNormal;
    endcase
  end

  logic any_hot;
  logic [7:0] spd_sel;
  logic [6:0] duty_new;
  always_comb begin
    any_hot = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (c < CHANNELS && st_q[c] != StNormal) any_hot = 1'b1;
    end
    spd_sel  = any_hot ? spd_hi_q : spd_no_q;
    duty_new = (spd_sel > 8'd100) ? 7'd100 : spd_sel[6:0];
  end

  logic [15:0] adc_cur;
  assign adc_cur = adc_q[ch_q];

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      ch_q <= 2'd0;
      for (int c = 0; c < 3; c++) st_q[c] <= StNormal;
      duty_q <= 7'd50;
      thr_hi_q <= 12'd650; thr_lo_q <= 12'd500; hyst_q <= 9'd50;
      spd_hi_q <= 8'd100; spd_no_q <= 8'd50; reload_q <= 16'd999;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgThrHigh:   thr_hi_q <= cfg_data_i[11:0];
          CfgThrLow:    thr_lo_q <= cfg_data_i[11:0];
          CfgHyst:      hyst_q   <= cfg_data_i[8:0];
          CfgSpeedHigh: spd_hi_q <= cfg_data_i[7:0];
          CfgSpeedNorm: spd_no_q <= cfg_data_i[7:0];
          CfgPwmReload: reload_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i && !in_stall_o) begin
          adc_q[0] <= {4'd0, in_data_i.adc_ch0};
          adc_q[1] <= {4'd0, in_data_i.adc_ch1};
          adc_q[2] <= {4'd0, in_data_i.adc_ch2};
          ch_q <= 2'd0;
          state_q <= S_CHAN;
        end
        S_CHAN: begin
          if (32'(ch_q) >= CHANNELS) begin
            temp_q[ch_q] <= '0;
            st_q[ch_q] <= StNormal;
            state_q <= S_NEXT;
          end else if (adc_cur == 16'd0 || 32'(adc_cur) >= ADC_FULL_SCALE) begin
            temp_q[ch_q] <= 12'(TableT0Tenths);
            state_q <= S_NEXT;
          end else begin
            num_q <= DW'(PULLUP_OHMS) * DW'(adc_cur);
            den_q <= DW'(ADC_FULL_SCALE) - DW'(adc_cur);
            rem_q <= '0;
            cnt_q <= CW'(DW);
            state_q <= S_RDIV;
          end
        end
        S_RDIV, S_FDIV: begin
          if (cnt_q != '0) begin
            rem_q <= sub_ok ? rem_sh - {1'b0, den_q} : rem_sh;
            num_q <= {num_q[DW-2:0], sub_ok};
            cnt_q <= cnt_q - CW'(1);
          end else if (state_q == S_RDIV) begin
            if (num_q >= DW'(ntc_ohms(8'd0))) begin
              temp_q[ch_q] <= 12'(TableT0Tenths);
              state_q <= S_NEXT;
            end else begin
              r_q <= num_q[17:0];
              idx_q <= 8'd1;
              state_q <= S_SRCH;
            end
          end else begin
            temp_q[ch_q] <= 12'(TableT0Tenths + 10 * (int'(idx_q) - 1)) + 12'(num_q[3:0]);
            state_q <= S_NEXT;
          end
        end
        S_SRCH: begin
          if (r_q >= tab_cur) begin
            num_q <= DW'((tab_prev - r_q) * 18'd10);
            den_q <= DW'(tab_prev - tab_cur);
            rem_q <= '0;
            cnt_q <= CW'(DW);
            state_q <= S_FDIV;
          end else if (idx_q == 8'(TablePoints - 1)) begin
            temp_q[ch_q] <= 12'(TableTopTenths);
            state_q <= S_NEXT;
          end else begin
            idx_q <= idx_q + 8'd1;
          end
        end
        S_NEXT: begin
          if (32'(ch_q) < CHANNELS) st_q[ch_q] <= st_new;
          if (ch_q == 2'd2) begin
            ch_q <= 2'd0;
            state_q <= S_DONE;
          end else begin
            ch_q <= ch_q + 2'd1;
            state_q <= S_CHAN;
          end
        end
        S_DONE: begin
          // Status has settled: choose the duty and form duty*(reload+1).
          duty_q  <= duty_new;
          num_q   <= DW'(24'(duty_new) * 24'({1'b0, reload_q} + 17'd1));
          state_q <= S_CDIV;
        end
        S_CDIV: begin
          out_q.pwm_compare <= cmp_prod[46:30];
          out_q.fan_duty    <= duty_q;
          out_q.temp_ch0    <= temp_q[0];
          out_q.temp_ch1    <= temp_q[1];
          out_q.temp_ch2    <= temp_q[2];
          out_q.status_ch0  <= st_q[0];
          out_q.status_ch1  <= st_q[1];
          out_q.status_ch2  <= st_q[2];
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fan_duty <= 7'd100)) else $error("duty over 100");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status_ch0 != 2'd3 && out_data_o.status_ch1 != 2'd3
      && out_data_o.status_ch2 != 2'd3)) else $error("bad status");

endmodule
`default_nettype wire
